[rtl/core/i2cm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam logic [4:0] P_IDLE      = 5'd0;
  localparam logic [4:0] P_START     = 5'd1;
  localparam logic [4:0] P_TX_ADDRW  = 5'd2;
  localparam logic [4:0] P_ACK_ADDRW = 5'd3;
  localparam logic [4:0] P_TX_REG    = 5'd4;
  localparam logic [4:0] P_ACK_REG   = 5'd5;
  localparam logic [4:0] P_RSTART    = 5'd6;
  localparam logic [4:0] P_TX_ADDRR  = 5'd7;
  localparam logic [4:0] P_ACK_ADDRR = 5'd8;
  localparam logic [4:0] P_TX_DATA   = 5'd9;
  localparam logic [4:0] P_ACK_DATA  = 5'd10;
  localparam logic [4:0] P_RX        = 5'd11;
  localparam logic [4:0] P_ACK_OUT   = 5'd12;
  localparam logic [4:0] P_STOP      = 5'd13;

  localparam logic [1:0] OP_SCL0 = 2'd0;
  localparam logic [1:0] OP_SCL1 = 2'd1;
  localparam logic [1:0] OP_SDA0 = 2'd2;
  localparam logic [1:0] OP_SDA1 = 2'd3;

  localparam logic [2:0] START_LEN = 3'd5;
  localparam logic [2:0] STOP_LEN  = 3'd6;

  typedef struct packed {
    logic       start_cmd;
    logic       func;
    logic [6:0] slave_addr;
    logic [7:0] reg_sel;
    logic [7:0] byte_count;
    logic [7:0] tx_byte;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       tx_byte_taken;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       busy_res;
    logic       done_res;
    logic       nack_error;
  } out_t;

  typedef struct packed {
    logic [4:0] phase;
    logic [2:0] step_in_phase;
    logic [3:0] bit_counter;
    logic [7:0] shift_reg;
    logic [7:0] bytes_left;
    logic [6:0] target_addr;
    logic [7:0] register_addr;
    logic       is_read;
    logic       error_flag;
    logic       scl;
    logic       sda;
    logic       drv;
  } state_t;

  function automatic logic [1:0] start_op(input logic [2:0] step);
    logic [1:0] op;
    case (step)
      3'd0:    op = OP_SCL0;
      3'd1:    op = OP_SDA1;
      3'd2:    op = OP_SCL1;
      3'd3:    op = OP_SDA0;
      3'd4:    op = OP_SCL0;
      default: op = OP_SCL1;
    endcase
    return op;
  endfunction

  function automatic logic [1:0] stop_op(input logic [2:0] step);
    logic [1:0] op;
    case (step)
      3'd0:    op = OP_SCL0;
      3'd1:    op = OP_SDA0;
      3'd2:    op = OP_SCL1;
      3'd3:    op = OP_SDA1;
      3'd4:    op = OP_SCL0;
      default: op = OP_SCL1;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

[rtl/core/i2c_master_register_access_unit.sv]
// I2C master for register writes and reads. Each input transfer is one bus
// tick and yields exactly one output transfer carrying the pin levels for
// that tick plus the status strobes. One tick is taken per clock cycle; its
// result appears in the output register on the next cycle. Throughput is set
// by the single registered step: the bus state advances only on input
// transfers, and input stalls while an output transfer is pending and not
// taken. A zero byte count is ignored; a slave NACK ends with STOP and
// nack_error alongside done_res.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_register_access_unit (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire i2cm_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output i2cm_pkg::out_t      result
);

  i2cm_pkg::state_t state;
  i2cm_pkg::state_t state_next;
  i2cm_pkg::out_t   res;
  logic             accept;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  i2cm_step u_step (
    .cur  (state),
    .item (in_data),
    .nxt  (state_next),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= i2cm_pkg::P_IDLE;
      state.step_in_phase <= 3'd0;
      state.bit_counter   <= 4'd0;
      state.shift_reg     <= 8'd0;
      state.bytes_left    <= 8'd0;
      state.target_addr   <= 7'd0;
      state.register_addr <= 8'd0;
      state.is_read       <= 1'b0;
      state.error_flag    <= 1'b0;
      state.scl           <= 1'b1;
      state.sda           <= 1'b1;
      state.drv           <= 1'b1;
      out_valid           <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/i2cm_step.sv]
`timescale 1ns / 1ps
`default_nettype none

module i2cm_step (
  input  wire i2cm_pkg::state_t cur,
  input  wire i2cm_pkg::in_t    item,
  output i2cm_pkg::state_t      nxt,
  output i2cm_pkg::out_t        res
);

  always_comb begin
    i2cm_pkg::state_t s;
    logic [1:0] op;
    logic       seq_done;
    logic       taken;
    logic       rxv;
    logic [7:0] rx;
    logic       busy;
    logic       done;
    logic       nerr;

    s        = cur;
    op       = i2cm_pkg::OP_SCL1;
    seq_done = 1'b0;
    taken    = 1'b0;
    rxv      = 1'b0;
    rx       = 8'd0;
    busy     = 1'b1;
    done     = 1'b0;
    nerr     = 1'b0;

    if (s.phase == i2cm_pkg::P_IDLE) begin
      if (item.start_cmd && item.byte_count != 8'd0) begin
        s.is_read       = item.func;
        s.target_addr   = item.slave_addr;
        s.register_addr = item.reg_sel;
        s.bytes_left    = item.byte_count;
        s.error_flag    = 1'b0;
        s.phase         = i2cm_pkg::P_START;
        s.step_in_phase = 3'd0;
        s.bit_counter   = 4'd0;
        s.shift_reg     = 8'd0;
      end else begin
        busy = 1'b0;
      end
    end

    unique case (s.phase)
      i2cm_pkg::P_IDLE: begin
      end
      i2cm_pkg::P_START, i2cm_pkg::P_RSTART, i2cm_pkg::P_STOP: begin
        if (s.phase == i2cm_pkg::P_STOP) begin
          op       = i2cm_pkg::stop_op(s.step_in_phase);
          seq_done = (s.step_in_phase + 3'd1) >= i2cm_pkg::STOP_LEN;
        end else begin
          op       = i2cm_pkg::start_op(s.step_in_phase);
          seq_done = (s.step_in_phase + 3'd1) >= i2cm_pkg::START_LEN;
        end
        case (op)
          i2cm_pkg::OP_SCL0: s.scl = 1'b0;
          i2cm_pkg::OP_SCL1: s.scl = 1'b1;
          i2cm_pkg::OP_SDA0: s.sda = 1'b0;
          default:           s.sda = 1'b1;
        endcase
        s.step_in_phase = s.step_in_phase + 3'd1;
        if (seq_done) begin
          s.step_in_phase = 3'd0;
          s.bit_counter   = 4'd0;
          if (s.phase == i2cm_pkg::P_STOP) begin
            done        = 1'b1;
            nerr        = s.error_flag;
            s.phase     = i2cm_pkg::P_IDLE;
            s.shift_reg = 8'd0;
          end else if (s.phase == i2cm_pkg::P_START) begin
            s.phase     = i2cm_pkg::P_TX_ADDRW;
            s.shift_reg = {s.target_addr, 1'b0};
          end else begin
            s.phase     = i2cm_pkg::P_TX_ADDRR;
            s.shift_reg = {s.target_addr, 1'b1};
          end
        end
      end
      i2cm_pkg::P_TX_ADDRW, i2cm_pkg::P_TX_REG, i2cm_pkg::P_TX_ADDRR,
      i2cm_pkg::P_TX_DATA: begin
        if (s.phase == i2cm_pkg::P_TX_DATA && s.bit_counter == 4'd0 &&
            s.step_in_phase == 3'd0) begin
          s.shift_reg = item.tx_byte;
          taken       = 1'b1;
        end
        if (s.bit_counter[3]) begin
          s.sda           = 1'b0;
          s.phase         = s.phase + 5'd1;
          s.step_in_phase = 3'd0;
          s.bit_counter   = 4'd0;
          s.shift_reg     = 8'd0;
        end else if (s.step_in_phase == 3'd0) begin
          s.sda           = s.shift_reg[7];
          s.step_in_phase = 3'd1;
        end else if (s.step_in_phase == 3'd1) begin
          s.scl           = 1'b1;
          s.step_in_phase = 3'd2;
        end else begin
          s.scl           = 1'b0;
          s.shift_reg     = {s.shift_reg[6:0], 1'b0};
          s.bit_counter   = s.bit_counter + 4'd1;
          s.step_in_phase = 3'd0;
        end
      end
      i2cm_pkg::P_ACK_ADDRW, i2cm_pkg::P_ACK_REG, i2cm_pkg::P_ACK_ADDRR,
      i2cm_pkg::P_ACK_DATA: begin
        case (s.step_in_phase)
          3'd0: begin
            s.drv           = 1'b0;
            s.step_in_phase = 3'd1;
          end
          3'd1: begin
            s.scl           = 1'b1;
            s.error_flag    = item.sda_in;
            s.step_in_phase = 3'd2;
          end
          3'd2: begin
            s.scl           = 1'b0;
            s.step_in_phase = 3'd3;
          end
          default: begin
            s.drv           = 1'b1;
            s.step_in_phase = 3'd0;
            s.bit_counter   = 4'd0;
            s.shift_reg     = 8'd0;
            if (s.error_flag) begin
              s.phase = i2cm_pkg::P_STOP;
            end else if (s.phase == i2cm_pkg::P_ACK_ADDRW) begin
              s.phase     = i2cm_pkg::P_TX_REG;
              s.shift_reg = s.register_addr;
            end else if (s.phase == i2cm_pkg::P_ACK_REG) begin
              s.phase = s.is_read ? i2cm_pkg::P_RSTART : i2cm_pkg::P_TX_DATA;
            end else if (s.phase == i2cm_pkg::P_ACK_ADDRR) begin
              s.phase = i2cm_pkg::P_RX;
            end else begin
              s.bytes_left = s.bytes_left - 8'd1;
              s.phase = (s.bytes_left == 8'd0) ? i2cm_pkg::P_STOP : i2cm_pkg::P_TX_DATA;
            end
          end
        endcase
      end
      i2cm_pkg::P_RX: begin
        if (s.step_in_phase == 3'd0) begin
          s.drv           = 1'b0;
          s.step_in_phase = 3'd1;
        end else if (s.step_in_phase == 3'd1) begin
          if (s.bit_counter[3]) begin
            s.drv           = 1'b1;
            rx              = s.shift_reg;
            rxv             = 1'b1;
            s.bytes_left    = s.bytes_left - 8'd1;
            s.phase         = i2cm_pkg::P_ACK_OUT;
            s.step_in_phase = 3'd0;
            s.bit_counter   = 4'd0;
            s.shift_reg     = 8'd0;
          end else begin
            s.scl           = 1'b1;
            s.shift_reg     = {s.shift_reg[6:0], item.sda_in};
            s.step_in_phase = 3'd2;
          end
        end else begin
          s.scl           = 1'b0;
          s.bit_counter   = s.bit_counter + 4'd1;
          s.step_in_phase = 3'd1;
        end
      end
      i2cm_pkg::P_ACK_OUT: begin
        if (s.step_in_phase == 3'd0) begin
          s.sda           = (s.bytes_left == 8'd0);
          s.step_in_phase = 3'd1;
        end else if (s.step_in_phase == 3'd1) begin
          s.scl           = 1'b1;
          s.step_in_phase = 3'd2;
        end else if (s.step_in_phase == 3'd2) begin
          s.scl           = 1'b0;
          s.step_in_phase = 3'd3;
        end else begin
          s.sda           = 1'b1;
          s.phase = (s.bytes_left == 8'd0) ? i2cm_pkg::P_STOP : i2cm_pkg::P_RX;
          s.step_in_phase = 3'd0;
          s.bit_counter   = 4'd0;
          s.shift_reg     = 8'd0;
        end
      end
      default: begin
        s.scl           = 1'b1;
        s.sda           = 1'b1;
        s.drv           = 1'b1;
        busy            = 1'b0;
        s.phase         = i2cm_pkg::P_IDLE;
        s.step_in_phase = 3'd0;
        s.bit_counter   = 4'd0;
        s.shift_reg     = 8'd0;
      end
    endcase

    nxt               = s;
    res.scl_out       = s.scl;
    res.sda_out       = s.sda;
    res.sda_drive     = s.drv;
    res.tx_byte_taken = taken;
    res.rx_byte       = rx;
    res.rx_valid      = rxv;
    res.busy_res      = busy;
    res.done_res      = done;
    res.nack_error    = nerr;
  end

endmodule

`default_nettype wire

[verif/i2c_bus_checker.sv]
`timescale 1ns / 1ps

module i2c_bus_checker
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        result,
  output logic [31:0] errors,
  output logic [31:0] outstanding,
  output logic [4:0]  bus_phase
);

  // pin op sequences, step 0 in the low bits
  localparam logic [9:0]  START_SEQ = {OP_SCL0, OP_SDA0, OP_SCL1, OP_SDA1, OP_SCL0};
  localparam logic [11:0] STOP_SEQ  = {OP_SCL1, OP_SCL0, OP_SDA1, OP_SCL1, OP_SDA0, OP_SCL0};

  logic [4:0] ph;
  logic [2:0] step;
  logic [3:0] nbits;
  logic [7:0] shreg;
  logic [7:0] remaining;
  logic [6:0] dev;
  logic [7:0] regad;
  logic       rd;
  logic       nacked;
  logic       scl;
  logic       sda;
  logic       drv;

  out_t pending_ticks[$];
  out_t want;
  int   depth = 0;
  int   fail_count = 0;

  assign errors      = fail_count;
  assign outstanding = depth;
  assign bus_phase   = ph;

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic void enter_phase(input logic [4:0] p, input logic [7:0] load);
    ph    = p;
    step  = 3'd0;
    nbits = 4'd0;
    shreg = load;
  endfunction

  function automatic void reset_model();
    enter_phase(P_IDLE, 8'h00);
    remaining = 8'h00;
    dev       = 7'h00;
    regad     = 8'h00;
    rd        = 1'b0;
    nacked    = 1'b0;
    scl       = 1'b1;
    sda       = 1'b1;
    drv       = 1'b1;
  endfunction

  function automatic logic play_seq(input logic [11:0] ops, input logic [2:0] len);
    logic [1:0] op;
    op = OP_SCL1;
    if (step < len) op = ops[2 * step +: 2];
    case (op)
      OP_SCL0: scl = 1'b0;
      OP_SCL1: scl = 1'b1;
      OP_SDA0: sda = 1'b0;
      default: sda = 1'b1;
    endcase
    step = step + 3'd1;
    return step >= len;
  endfunction

  function automatic out_t bus_tick(input in_t t);
    out_t r;
    r = '0;
    r.busy_res = 1'b1;
    if (ph == P_IDLE) begin
      if (t.start_cmd && t.byte_count != 8'd0) begin
        rd        = t.func;
        dev       = t.slave_addr;
        regad     = t.reg_sel;
        remaining = t.byte_count;
        nacked    = 1'b0;
        enter_phase(P_START, 8'h00);
      end else begin
        r.busy_res = 1'b0;
      end
    end
    case (ph)
      P_IDLE: ;
      P_START: begin
        if (play_seq({2'b00, START_SEQ}, 3'd5)) enter_phase(P_TX_ADDRW, {dev, 1'b0});
      end
      P_RSTART: begin
        if (play_seq({2'b00, START_SEQ}, 3'd5)) enter_phase(P_TX_ADDRR, {dev, 1'b1});
      end
      P_TX_ADDRW, P_TX_REG, P_TX_ADDRR, P_TX_DATA: begin
        if (ph == P_TX_DATA && nbits == 4'd0 && step == 3'd0) begin
          shreg = t.tx_byte;
          r.tx_byte_taken = 1'b1;
        end
        if (nbits >= 4'd8) begin
          sda = 1'b0;
          enter_phase(ph + 5'd1, 8'h00);
        end else if (step == 3'd0) begin
          sda  = shreg[7];
          step = 3'd1;
        end else if (step == 3'd1) begin
          scl  = 1'b1;
          step = 3'd2;
        end else begin
          scl   = 1'b0;
          shreg = shreg << 1;
          nbits = nbits + 4'd1;
          step  = 3'd0;
        end
      end
      P_ACK_ADDRW, P_ACK_REG, P_ACK_ADDRR, P_ACK_DATA: begin
        case (step)
          3'd0: drv = 1'b0;
          3'd1: begin
            scl    = 1'b1;
            nacked = t.sda_in;
          end
          3'd2: scl = 1'b0;
          default: drv = 1'b1;
        endcase
        if (step < 3'd3) begin
          step = step + 3'd1;
        end else if (nacked) begin
          enter_phase(P_STOP, 8'h00);
        end else if (ph == P_ACK_ADDRW) begin
          enter_phase(P_TX_REG, regad);
        end else if (ph == P_ACK_REG) begin
          enter_phase(rd ? P_RSTART : P_TX_DATA, 8'h00);
        end else if (ph == P_ACK_ADDRR) begin
          enter_phase(P_RX, 8'h00);
        end else begin
          remaining = remaining - 8'd1;
          enter_phase(remaining == 8'd0 ? P_STOP : P_TX_DATA, 8'h00);
        end
      end
      P_RX: begin
        if (step == 3'd0) begin
          drv  = 1'b0;
          step = 3'd1;
        end else if (step == 3'd1) begin
          if (nbits >= 4'd8) begin
            drv        = 1'b1;
            r.rx_byte  = shreg;
            r.rx_valid = 1'b1;
            remaining  = remaining - 8'd1;
            enter_phase(P_ACK_OUT, 8'h00);
          end else begin
            scl   = 1'b1;
            shreg = {shreg[6:0], t.sda_in};
            step  = 3'd2;
          end
        end else begin
          scl   = 1'b0;
          nbits = nbits + 4'd1;
          step  = 3'd1;
        end
      end
      P_ACK_OUT: begin
        if (step == 3'd0) begin
          sda  = (remaining == 8'd0);
          step = 3'd1;
        end else if (step == 3'd1) begin
          scl  = 1'b1;
          step = 3'd2;
        end else if (step == 3'd2) begin
          scl  = 1'b0;
          step = 3'd3;
        end else begin
          sda = 1'b1;
          enter_phase(remaining == 8'd0 ? P_STOP : P_RX, 8'h00);
        end
      end
      P_STOP: begin
        if (play_seq(STOP_SEQ, 3'd6)) begin
          r.done_res   = 1'b1;
          r.nack_error = nacked;
          enter_phase(P_IDLE, 8'h00);
        end
      end
      default: begin
        scl        = 1'b1;
        sda        = 1'b1;
        drv        = 1'b1;
        r.busy_res = 1'b0;
        enter_phase(P_IDLE, 8'h00);
      end
    endcase
    r.scl_out   = scl;
    r.sda_out   = sda;
    r.sda_drive = drv;
    return r;
  endfunction

  initial reset_model();

  always @(posedge clk) begin
    if (rst) begin
      reset_model();
      pending_ticks.delete();
      depth = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_ticks.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = pending_ticks.pop_front();
          depth = depth - 1;
          if (result !== want) begin
            report_mismatch($sformatf("result got %h, expected %h", result, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_ticks.push_back(bus_tick(in_data));
        depth = depth + 1;
      end
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import i2cm_pkg::*;

  localparam int ITEMS = 950;
  localparam int TAIL  = 150;
  localparam int LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        result;
  logic [31:0] errors;
  logic [31:0] outstanding;
  logic [4:0]  bus_phase;

  bit in_gaps  = 1'b1;
  bit out_gaps = 1'b1;
  int hold_left = 0;
  int ticks = 0;
  int cycle_count = 0;

  i2c_master_register_access_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
  );

  i2c_bus_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .errors      (errors),
    .outstanding (outstanding),
    .bus_phase   (bus_phase)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (out_gaps && $urandom_range(0, 4) == 0) begin
      hold_left <= $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic in_t random_tick();
    in_t t;
    t.start_cmd  = 1'($urandom_range(0, 1));
    t.func       = 1'($urandom_range(0, 1));
    t.slave_addr = 7'($urandom_range(0, 127));
    t.reg_sel    = 8'($urandom_range(0, 255));
    t.byte_count = 8'($urandom_range(0, 255));
    t.tx_byte    = 8'($urandom_range(0, 255));
    t.sda_in     = 1'($urandom_range(0, 1));
    return t;
  endfunction

  task automatic drive_tick(input in_t t);
    if (in_gaps && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // idle-bus noise: no start, or a start with zero length
  task automatic idle_noise();
    in_t t;
    t = random_tick();
    if (t.start_cmd) t.byte_count = 8'd0;
    drive_tick(t);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic run_command(input logic rd, input logic [6:0] dev, input logic [7:0] ra,
                             input logic [7:0] len, input logic [4:0] nack_at,
                             input int nack_odds);
    in_t t;
    t = random_tick();
    t.start_cmd  = 1'b1;
    t.func       = rd;
    t.slave_addr = dev;
    t.reg_sel    = ra;
    t.byte_count = len;
    drive_tick(t);
    if (len != 8'd0) ticks++;
    while (bus_phase != P_IDLE) begin
      t = random_tick();
      if (bus_phase == P_ACK_ADDRW || bus_phase == P_ACK_REG ||
          bus_phase == P_ACK_ADDRR || bus_phase == P_ACK_DATA) begin
        t.sda_in = (bus_phase == nack_at) ||
                   (nack_odds != 0 && $urandom_range(1, nack_odds) == 1);
      end
      drive_tick(t);
      ticks++;
    end
  endtask

  initial begin
    int len;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    idle_noise();
    run_command(1'b0, 7'h55, 8'h10, 8'd0, P_IDLE, 0);
    run_command(1'b1, 7'h2B, 8'h01, 8'd0, P_IDLE, 0);
    run_command(1'b0, 7'h7F, 8'hFF, 8'd1, P_IDLE, 0);
    run_command(1'b1, 7'h00, 8'h00, 8'd1, P_IDLE, 0);
    run_command(1'b0, 7'h40, 8'h80, 8'd2, P_ACK_ADDRW, 0);
    run_command(1'b1, 7'h33, 8'hCC, 8'd2, P_ACK_REG, 0);
    run_command(1'b1, 7'h4C, 8'h3C, 8'd2, P_ACK_ADDRR, 0);
    run_command(1'b0, 7'h5A, 8'h00, 8'd255, P_ACK_DATA, 0);
    idle_noise();
    drain();

    while (ticks < ITEMS) begin
      if (ticks >= ITEMS - TAIL) begin
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
      end else begin
        in_gaps  = $urandom_range(0, 3) != 0;
        out_gaps = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) idle_noise();
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        run_command(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    8'($urandom_range(0, 255)), 8'(len), P_IDLE,
                    ($urandom_range(0, 3) == 0) ? 6 : 0);
      end
      if (ticks < ITEMS - TAIL && $urandom_range(0, 5) == 0) drain();
    end

    in_valid <= 1'b0;
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[i2c_master_register_access_unit.f]
rtl/core/i2cm_pkg.sv
rtl/core/i2cm_step.sv
rtl/core/i2c_master_register_access_unit.sv
verif/i2c_bus_checker.sv
verif/testbench.sv
